FILE: rtl/md5_pkg.sv
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam int unsigned BlockWords = 16;
  localparam int unsigned LenWord = 14;

  // Command from the controller to the datapath for one cycle.
  typedef struct packed {
    logic       put_byte;   // merge data byte into the word buffer
    logic       put_pad;    // merge 0x80 at the current position
    logic       zero_word;  // clear word at given index
    logic       len_lo;     // write low length word
    logic       len_hi;     // write high length word
    logic [3:0] word_idx;
    logic       round_start;
    logic       round_step;
    logic [5:0] round_idx;
    logic       chain_add;
    logic       count_add;
    logic       reinit;
  } md5_cmd_t;

  typedef struct packed {
    logic [5:0] byte_pos;
  } md5_stat_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Message word index used by a round.
  function automatic logic [3:0] word_sel(input logic [5:0] i);
    logic [3:0] g;
    logic [3:0] n;
    n = i[3:0];
    case (i[5:4])
      2'd0: g = n;
      2'd1: g = 4'((n << 2) + n + 4'd1);
      2'd2: g = 4'((n << 1) + n + 4'd5);
      default: g = 4'((n << 3) - n);
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/md5_stream_if.sv
interface md5_stream_if #(
  parameter int unsigned Width = 10
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/md5_message_digest.sv
// Channel | Dir | Payload bits
// in_if   | in  | [9] end_of_message, [8] byte_present, [7:0] data_byte
// out_if  | out | [127:64] digest_high, [63:0] digest_low
//
// A byte beat is taken while idle; the beat that fills a block also runs the
// rounds and a chaining add, all through the single shared round unit.
// An end beat adds a pad step, word-clear steps and a compression, plus a
// second clear pass and a second compression when the length does not fit,
// then holds the digest until the output beat is taken.
// Reset (rst_ni low, asynchronous) restores the initial chaining words and
// a zero bit count; input is stalled while a block compresses.
module md5_message_digest (
  input logic           clk_i,
  input logic           rst_ni,
  md5_stream_if.sink    in_if,
  md5_stream_if.source  out_if
);

  md5_pkg::md5_cmd_t  cmd;
  md5_pkg::md5_stat_t stat;
  logic [127:0]       digest;

  md5_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_if.valid),
    .in_ready_o      (in_if.ready),
    .byte_present_i  (in_if.payload[8]),
    .end_of_message_i(in_if.payload[9]),
    .out_valid_o     (out_if.valid),
    .out_ready_i     (out_if.ready),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  md5_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .data_byte_i(in_if.payload[7:0]),
    .stat_o     (stat),
    .digest_o   (digest)
  );

  assign out_if.payload = digest;

endmodule

FILE: rtl/md5_datapath.sv
module md5_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  md5_pkg::md5_cmd_t cmd_i,
  input  logic [7:0]        data_byte_i,
  output md5_pkg::md5_stat_t stat_o,
  output logic [127:0]      digest_o
);

  logic [31:0] words_q [md5_pkg::BlockWords];
  logic [31:0] chain_q [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [63:0] count_q;
  logic [7:0]  merge_byte;
  logic        merge_en;
  logic [3:0]  merge_word;
  logic [31:0] f, t, s, rot;
  logic [4:0]  ra;

  assign stat_o.byte_pos = count_q[8:3];
  assign merge_en   = cmd_i.put_byte | cmd_i.put_pad;
  assign merge_byte = cmd_i.put_pad ? md5_pkg::PadByte : data_byte_i;
  assign merge_word = count_q[8:5];

  // Message buffer held as sixteen words, bytes little-endian within each.
  // A merged byte clears the bytes above it, so the pad leaves zeros behind it.
  always_ff @(posedge clk_i) begin
    if (merge_en) begin
      case (count_q[4:3])
        2'd0: words_q[merge_word] <= {24'd0, merge_byte};
        2'd1: words_q[merge_word][31:8] <= {16'd0, merge_byte};
        2'd2: words_q[merge_word][31:16] <= {8'd0, merge_byte};
        default: words_q[merge_word][31:24] <= merge_byte;
      endcase
    end
    if (cmd_i.zero_word) begin
      words_q[cmd_i.word_idx] <= '0;
    end
    if (cmd_i.len_lo) begin
      words_q[md5_pkg::LenWord] <= count_q[31:0];
    end
    if (cmd_i.len_hi) begin
      words_q[md5_pkg::LenWord + 1] <= count_q[63:32];
    end
  end

  // One MD5 round per cycle.
  always_comb begin
    unique case (cmd_i.round_idx[5:4])
      2'd0: f = (b_q & c_q) | (~b_q & d_q);
      2'd1: f = (b_q & d_q) | (c_q & ~d_q);
      2'd2: f = b_q ^ c_q ^ d_q;
      default: f = c_q ^ (b_q | ~d_q);
    endcase
    ra  = md5_pkg::rot_amount(cmd_i.round_idx);
    s   = a_q + f + words_q[md5_pkg::word_sel(cmd_i.round_idx)]
          + md5_pkg::round_const(cmd_i.round_idx);
    rot = (s << ra) | (s >> (6'd32 - {1'b0, ra}));
    t   = b_q + rot;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.round_start) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
    end else if (cmd_i.round_step) begin
      a_q <= d_q;
      d_q <= c_q;
      c_q <= b_q;
      b_q <= t;
    end
  end

  // Chaining words and bit count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q[0] <= md5_pkg::InitA;
      chain_q[1] <= md5_pkg::InitB;
      chain_q[2] <= md5_pkg::InitC;
      chain_q[3] <= md5_pkg::InitD;
      count_q    <= '0;
    end else begin
      if (cmd_i.reinit) begin
        chain_q[0] <= md5_pkg::InitA;
        chain_q[1] <= md5_pkg::InitB;
        chain_q[2] <= md5_pkg::InitC;
        chain_q[3] <= md5_pkg::InitD;
        count_q    <= '0;
      end else begin
        if (cmd_i.chain_add) begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
        end
        if (cmd_i.count_add) begin
          count_q <= count_q + 64'd8;
        end
      end
    end
  end

  assign digest_o = {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};

endmodule

FILE: rtl/md5_ctrl.sv
module md5_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               byte_present_i,
  input  logic               end_of_message_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  md5_pkg::md5_stat_t stat_i,
  output md5_pkg::md5_cmd_t  cmd_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPad   = 3'd1;
  localparam logic [2:0] StZero  = 3'd2;
  localparam logic [2:0] StRound = 3'd3;
  localparam logic [2:0] StAdd   = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [3:0] widx_q, widx_d;
  logic       fin_q, fin_d;     // message is being finished
  logic       last_q, last_d;   // this compression is the final one
  logic       accept;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign accept      = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    widx_d  = widx_q;
    fin_d   = fin_q;
    last_d  = last_q;
    cmd_o   = '0;
    cmd_o.round_idx = rnd_q;
    cmd_o.word_idx  = widx_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          fin_d  = end_of_message_i;
          last_d = 1'b0;
          if (byte_present_i) begin
            cmd_o.put_byte  = 1'b1;
            cmd_o.count_add = 1'b1;
            if (stat_i.byte_pos == 6'd63) begin
              cmd_o.round_start = 1'b1;
              rnd_d   = '0;
              state_d = StRound;
            end else if (end_of_message_i) begin
              state_d = StPad;
            end
          end else if (end_of_message_i) begin
            state_d = StPad;
          end
        end
      end
      StPad: begin
        // Append 0x80, then clear the words that follow it, unless the pad went into the last word.
        cmd_o.put_pad = 1'b1;
        widx_d  = 4'(stat_i.byte_pos[5:2] + 4'd1);
        if (stat_i.byte_pos[5:2] == 4'd15) begin
          cmd_o.round_start = 1'b1;
          rnd_d   = '0;
          state_d = StRound;
        end else begin
          state_d = StZero;
        end
      end
      StZero: begin
        // The length block keeps its last two words for the bit count.
        if ((stat_i.byte_pos >= 6'd56 && !last_q) || widx_q < 4'(md5_pkg::LenWord)) begin
          cmd_o.zero_word = 1'b1;
        end
        if (widx_q == 4'd15) begin
          if (stat_i.byte_pos < 6'd56 || last_q) begin
            cmd_o.len_lo = 1'b1;
            cmd_o.len_hi = 1'b1;
            last_d = 1'b1;
          end
          cmd_o.round_start = 1'b1;
          rnd_d   = '0;
          state_d = StRound;
        end else begin
          widx_d = 4'(widx_q + 4'd1);
        end
      end
      StRound: begin
        cmd_o.round_step = 1'b1;
        rnd_d = 6'(rnd_q + 6'd1);
        if (rnd_q == 6'd63) begin
          state_d = StAdd;
        end
      end
      StAdd: begin
        cmd_o.chain_add = 1'b1;
        if (!fin_q) begin
          state_d = StIdle;
        end else if (last_q) begin
          state_d = StOut;
        end else if (stat_i.byte_pos == 6'd0) begin
          // The final byte filled the block, so the pad has not gone in yet.
          state_d = StPad;
        end else if (stat_i.byte_pos >= 6'd56) begin
          // Second padding block: all zero but the length.
          widx_d  = '0;
          state_d = StZero;
          last_d  = 1'b1;
        end else begin
          state_d = StIdle;
        end
      end
      StOut: begin
        if (out_ready_i) begin
          cmd_o.reinit = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      rnd_q   <= '0;
      widx_q  <= '0;
      fin_q   <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      widx_q  <= widx_d;
      fin_q   <= fin_d;
      last_q  <= last_d;
    end
  end

endmodule

FILE: rtl/md5_checker.sv
module md5_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         in_valid_i,
  input logic         in_ready_i,
  input logic         out_valid_i,
  input logic         out_ready_i,
  input logic [127:0] out_payload_i
);

  // A waiting digest stays put.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("digest changed while stalled");

  // No input is taken while a digest waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready during digest hold");

  // After a digest beat the block is ready again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i |=> in_ready_i && !out_valid_i)
    else $error("not idle after digest");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_if.valid),
  .in_ready_i   (in_if.ready),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .out_payload_i(out_if.payload)
);
